// ===== rtl/plb_pkg.sv =====
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the price level book.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plb_pkg;

  localparam int unsigned DefaultLevels = 64;
  localparam int unsigned PriceW        = 32;
  localparam int unsigned SizeW         = 48;
  localparam int unsigned CountW        = 7;
  localparam int unsigned MidW          = 33;

  localparam logic KindUpdate = 1'b0;
  localparam logic KindClear  = 1'b1;
  localparam logic SideBid    = 1'b0;
  localparam logic SideAsk    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEARCH,
    ST_APPLY,
    ST_SCAN,
    ST_DONE
  } plb_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic search_step;
    logic apply;
    logic scan_start;
    logic scan_step;
    logic publish;
  } plb_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic last_slot;
  } plb_stat_t;

endpackage

// ===== rtl/plb_ctrl.sv =====
// ----------------------------------------------------------------------------
// plb_ctrl
// Controller: sequences search, apply and the top-of-book scan per update, and the scan alone per clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_busy,
  input  plb_pkg::plb_stat_t stat,
  output plb_pkg::plb_cmd_t  cmd,
  output logic               idle
);

  plb_pkg::plb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plb_pkg::ST_IDLE:   if (in_fire) state_nxt = plb_pkg::ST_CLEAR;
      plb_pkg::ST_CLEAR: begin
        state_nxt = stat.is_clear ? plb_pkg::ST_SCAN : plb_pkg::ST_SEARCH;
      end
      plb_pkg::ST_SEARCH: if (stat.last_slot) state_nxt = plb_pkg::ST_APPLY;
      plb_pkg::ST_APPLY:  state_nxt = plb_pkg::ST_SCAN;
      plb_pkg::ST_SCAN:   if (stat.last_slot) state_nxt = plb_pkg::ST_DONE;
      plb_pkg::ST_DONE:   if (!out_busy) state_nxt = plb_pkg::ST_IDLE;
      default:            state_nxt = plb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state_r)
      plb_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_fire;
      end
      plb_pkg::ST_CLEAR: begin
        cmd.clear      = stat.is_clear;
        cmd.scan_start = 1'b1;
      end
      plb_pkg::ST_SEARCH: cmd.search_step = 1'b1;
      plb_pkg::ST_APPLY: begin
        cmd.apply      = 1'b1;
        cmd.scan_start = 1'b1;
      end
      plb_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      plb_pkg::ST_DONE:   cmd.publish = !out_busy;
      default:            cmd = '0;
    endcase
  end

  ap_clear_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::ST_CLEAR && stat.is_clear) |=> state_r == plb_pkg::ST_SCAN)
    else $error("clear went to search");
  ap_apply_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == plb_pkg::ST_APPLY |=> state_r == plb_pkg::ST_SCAN)
    else $error("apply not followed by scan");
  ap_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> idle)
    else $error("load outside idle");

endmodule

// ===== rtl/plb_datapath.sv =====
// ----------------------------------------------------------------------------
// plb_datapath
// Level tables, slot-serial search and scan, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plb_datapath #(
  parameter int unsigned LEVELS = plb_pkg::DefaultLevels
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  plb_pkg::plb_cmd_t           cmd,
  output plb_pkg::plb_stat_t          stat,
  input  logic                        in_kind,
  input  logic                        in_side,
  input  logic [plb_pkg::PriceW-1:0]  in_price,
  input  logic [plb_pkg::SizeW-1:0]   in_size,
  output logic                        res_valid,
  input  logic                        res_taken,
  output logic [plb_pkg::PriceW-1:0]  res_best_bid,
  output logic [plb_pkg::PriceW-1:0]  res_best_ask,
  output logic [plb_pkg::MidW-1:0]    res_mid,
  output logic [plb_pkg::CountW-1:0]  res_bid_levels,
  output logic [plb_pkg::CountW-1:0]  res_ask_levels,
  output logic                        res_ok,
  output logic                        res_ovf
);

  localparam int unsigned IdxW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CntW = $clog2(LEVELS + 1);

  logic [plb_pkg::PriceW-1:0] bid_price_mem [LEVELS];
  logic [plb_pkg::PriceW-1:0] ask_price_mem [LEVELS];
  logic [plb_pkg::SizeW-1:0]  bid_size_mem  [LEVELS];
  logic [plb_pkg::SizeW-1:0]  ask_size_mem  [LEVELS];
  logic [LEVELS-1:0]          bid_vld_r, ask_vld_r;

  logic                       kind_r, side_r;
  logic [plb_pkg::PriceW-1:0] price_r;
  logic [plb_pkg::SizeW-1:0]  size_r;
  logic [IdxW-1:0]            idx_r, idx_nxt;
  logic                       hit_r, free_r;
  logic [IdxW-1:0]            hit_idx_r, free_idx_r;
  logic                       ovf_r;
  logic [plb_pkg::PriceW-1:0] bb_r, ba_r;
  logic [CntW-1:0]            nb_r, na_r;
  logic                       res_valid_r;

  logic [plb_pkg::PriceW-1:0] bid_rd_r, ask_rd_r, side_rd;
  logic                       bid_v, ask_v, side_v;
  logic                       ins_w;

  // price tables use a registered read port addressed by the next slot index
  assign bid_v  = bid_vld_r[idx_r];
  assign ask_v  = ask_vld_r[idx_r];
  assign side_rd = side_r ? ask_rd_r : bid_rd_r;
  assign side_v  = side_r ? ask_v : bid_v;

  assign stat.is_clear  = kind_r;
  assign stat.last_slot = (idx_r == IdxW'(LEVELS - 1));

  assign ins_w = cmd.apply && size_r != '0 && !hit_r && free_r;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) idx_nxt = '0;
    if (cmd.search_step) idx_nxt = stat.last_slot ? '0 : idx_r + 1'b1;
    if (cmd.scan_start) idx_nxt = '0;
    if (cmd.scan_step) idx_nxt = stat.last_slot ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    bid_rd_r <= (ins_w && !side_r && free_idx_r == idx_nxt) ? price_r
                                                             : bid_price_mem[idx_nxt];
    ask_rd_r <= (ins_w && side_r && free_idx_r == idx_nxt) ? price_r
                                                            : ask_price_mem[idx_nxt];
    if (cmd.load) begin
      kind_r  <= in_kind;
      side_r  <= in_side;
      price_r <= in_price;
      size_r  <= in_size;
    end
    if (ins_w) begin
      if (side_r) begin
        ask_price_mem[free_idx_r] <= price_r;
        ask_size_mem[free_idx_r]  <= size_r;
      end else begin
        bid_price_mem[free_idx_r] <= price_r;
        bid_size_mem[free_idx_r]  <= size_r;
      end
    end else if (cmd.apply && size_r != '0 && hit_r) begin
      if (side_r) begin
        ask_size_mem[hit_idx_r] <= size_r;
      end else begin
        bid_size_mem[hit_idx_r] <= size_r;
      end
    end
    if (cmd.search_step) begin
      if (side_v && !hit_r && side_rd == price_r) begin
        hit_idx_r <= idx_r;
      end
      if (!side_v && !free_r) begin
        free_idx_r <= idx_r;
      end
    end
    if (cmd.scan_step) begin
      if (bid_v) begin
        if (nb_r == '0 || bid_rd_r > bb_r) bb_r <= bid_rd_r;
      end
      if (ask_v) begin
        if (na_r == '0 || ask_rd_r < ba_r) ba_r <= ask_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_vld_r   <= '0;
      ask_vld_r   <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      ovf_r       <= 1'b0;
      nb_r        <= '0;
      na_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (res_taken) res_valid_r <= 1'b0;
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        ovf_r  <= 1'b0;
      end
      if (cmd.clear) begin
        bid_vld_r <= '0;
        ask_vld_r <= '0;
      end
      if (cmd.search_step) begin
        if (side_v && side_rd == price_r) hit_r <= 1'b1;
        if (!side_v) free_r <= 1'b1;
      end
      if (cmd.apply) begin
        if (size_r == '0) begin
          if (hit_r) begin
            if (side_r) ask_vld_r[hit_idx_r] <= 1'b0;
            else        bid_vld_r[hit_idx_r] <= 1'b0;
          end
        end else if (!hit_r) begin
          if (free_r) begin
            if (side_r) ask_vld_r[free_idx_r] <= 1'b1;
            else        bid_vld_r[free_idx_r] <= 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (cmd.scan_start) begin
        nb_r  <= '0;
        na_r  <= '0;
      end
      if (cmd.scan_step) begin
        if (bid_v) nb_r <= nb_r + 1'b1;
        if (ask_v) na_r <= na_r + 1'b1;
      end
      if (cmd.publish) res_valid_r <= 1'b1;
    end
  end

  logic ok_w;
  assign ok_w = (nb_r != '0) && (na_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_best_bid   <= (nb_r != '0) ? bb_r : '0;
      res_best_ask   <= (na_r != '0) ? ba_r : '0;
      res_mid        <= ok_w ? ({1'b0, bb_r} + {1'b0, ba_r}) : '0;
      res_bid_levels <= plb_pkg::CountW'(nb_r);
      res_ask_levels <= plb_pkg::CountW'(na_r);
      res_ok         <= ok_w;
      res_ovf        <= ovf_r;
    end
  end

  assign res_valid = res_valid_r;

  ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    nb_r <= CntW'(LEVELS) && na_r <= CntW'(LEVELS))
    else $error("level count out of range");
  ap_ovf_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && ovf_r == 1'b0 && size_r != '0 && !hit_r && !free_r) |=> ovf_r)
    else $error("overflow not flagged");
  ap_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (bid_vld_r == '0 && ask_vld_r == '0))
    else $error("clear left levels");

endmodule

// ===== rtl/price_level_book_top.sv =====
// ----------------------------------------------------------------------------
// price_level_book_top
// Bounded bid/ask level book with top-of-book report per transaction.
//
//  channel | dir | fields
//  in_     | in  | tdata: price_ticks[31:0], level_size[79:32]; tuser: kind, side
//  out_    | out | tdata: best_bid, best_ask, mid_half_ticks, bid/ask_levels,
//          |     |        book_ok, overflow
//
// An update makes two serial passes (a clear makes only the second):
// one pass over the side's slots to find a match and a free slot, and
// one pass over both tables for best prices and counts.
// Reset clears all valid marks at once; no clearing pass.
// The result is held in an output register; a stalled output holds the
// controller in its done state until the previous result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_level_book_top #(
  parameter int unsigned LEVELS_PER_SIDE = plb_pkg::DefaultLevels
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // price_ticks[31:0], level_size[79:32]
  input  logic [1:0]   in_tuser,   // kind[0], side[1]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // best_bid, best_ask, mid_half_ticks,
                                   // bid_levels, ask_levels, book_ok, overflow
);

  plb_pkg::plb_cmd_t  cmd;
  plb_pkg::plb_stat_t stat;
  logic idle, res_valid;
  logic [31:0] bb, ba;
  logic [32:0] mid;
  logic [6:0]  nb, na;
  logic        ok, ovf;

  assign in_tready = idle;

  plb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid & in_tready),
    .out_busy (res_valid & ~out_tready),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  plb_datapath #(.LEVELS(LEVELS_PER_SIDE)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_tuser[0]),
    .in_side        (in_tuser[1]),
    .in_price       (in_tdata[31:0]),
    .in_size        (in_tdata[79:32]),
    .res_valid      (res_valid),
    .res_taken      (out_tready),
    .res_best_bid   (bb),
    .res_best_ask   (ba),
    .res_mid        (mid),
    .res_bid_levels (nb),
    .res_ask_levels (na),
    .res_ok         (ok),
    .res_ovf        (ovf)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {7'd0, ovf, ok, na, nb, mid, ba, bb};

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for price_level_book_top.
//
// A directed table covers the field extremes, removal of an absent price,
// clears carrying junk fields, an empty book and a bid side filled up to
// overflow. Rows with a hand-written result are checked against it. All other
// rows, and the random traffic after them, are checked against a behavioral
// book model in this file.
// The random traffic mostly draws prices from a narrow pool, so levels are
// hit, removed and refilled. It runs through several phases of source and
// sink idling, one long sink hold-off and one drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Levels   = 64;
  localparam int unsigned MaxCycle = 2000000;
  localparam int unsigned NumRand  = 365;

  typedef struct packed {
    logic [plb_pkg::PriceW-1:0] best_bid;
    logic [plb_pkg::PriceW-1:0] best_ask;
    logic [plb_pkg::MidW-1:0]   mid;
    logic [plb_pkg::CountW-1:0] nbid;
    logic [plb_pkg::CountW-1:0] nask;
    logic                       ok;
    logic                       ovf;
  } tob_t;

  typedef struct {
    logic                       kind;
    logic                       side;
    logic [plb_pkg::PriceW-1:0] price;
    logic [plb_pkg::SizeW-1:0]  qty;
    bit                         typed;
    tob_t                       res;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [79:0]   in_tdata = '0;
  logic [1:0]    in_tuser = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [119:0]  out_tdata;

  logic [plb_pkg::PriceW-1:0] lvl_price [2][Levels];
  logic [plb_pkg::SizeW-1:0]  lvl_qty   [2][Levels];
  bit                         lvl_live  [2][Levels];

  tob_t    tob_queue[$];
  row_t    dir_rows[$];
  int      errors = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  bit      rx_hold = 1'b0;
  longint  cycles = 0;

  price_level_book_top #(.LEVELS_PER_SIDE(Levels)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("%0t timeout", $time);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic tob_t book_step(logic kind, logic side,
                                     logic [plb_pkg::PriceW-1:0] price,
                                     logic [plb_pkg::SizeW-1:0] qty);
    tob_t r;
    int hit, free, s;
    int unsigned cnt [2];
    logic [plb_pkg::PriceW-1:0] best [2];
    r = '0;
    if (kind == plb_pkg::KindClear) begin
      for (int i = 0; i < Levels; i++) begin
        lvl_live[0][i] = 0;
        lvl_live[1][i] = 0;
      end
    end else begin
      s = (side == plb_pkg::SideAsk) ? 1 : 0;
      hit = -1;
      free = -1;
      for (int i = 0; i < Levels; i++) begin
        if (lvl_live[s][i]) begin
          if (hit < 0 && lvl_price[s][i] == price) hit = i;
        end else if (free < 0) begin
          free = i;
        end
      end
      if (qty == 0) begin
        if (hit >= 0) lvl_live[s][hit] = 0;
      end else if (hit >= 0) begin
        lvl_qty[s][hit] = qty;
      end else if (free < 0) begin
        r.ovf = 1'b1;
      end else begin
        lvl_price[s][free] = price;
        lvl_qty[s][free] = qty;
        lvl_live[s][free] = 1;
      end
    end
    for (int k = 0; k < 2; k++) begin
      cnt[k] = 0;
      best[k] = '0;
      for (int i = 0; i < Levels; i++) begin
        if (lvl_live[k][i]) begin
          if (cnt[k] == 0 || (k == 0 ? lvl_price[k][i] > best[k]
                                     : lvl_price[k][i] < best[k]))
            best[k] = lvl_price[k][i];
          cnt[k]++;
        end
      end
    end
    r.best_bid = best[0];
    r.best_ask = best[1];
    r.nbid = cnt[0][plb_pkg::CountW-1:0];
    r.nask = cnt[1][plb_pkg::CountW-1:0];
    r.ok = (cnt[0] != 0) && (cnt[1] != 0);
    r.mid = r.ok ? ({1'b0, best[0]} + {1'b0, best[1]}) : '0;
    return r;
  endfunction

  task automatic send_item(logic kind, logic side, logic [plb_pkg::PriceW-1:0] price,
                           logic [plb_pkg::SizeW-1:0] qty, bit typed, tob_t typed_res);
    int gap;
    tob_t p;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {qty, price};
    in_tuser <= {side, kind};
    do @(posedge clk); while (!in_tready);
    p = book_step(kind, side, price, qty);
    tob_queue.push_back(typed ? typed_res : p);
  endtask

  task automatic send_random(int pool);
    logic kind, side;
    logic [plb_pkg::PriceW-1:0] price;
    logic [plb_pkg::SizeW-1:0] qty;
    kind = ($urandom_range(99) < 3) ? plb_pkg::KindClear : plb_pkg::KindUpdate;
    side = 1'($urandom_range(1));
    if ($urandom_range(99) < 10) price = $urandom;
    else price = 32'd1000 + $urandom_range(pool);
    if ($urandom_range(99) < 20) qty = '0;
    else qty = 48'({$urandom, $urandom});
    send_item(kind, side, price, qty, 1'b0, '0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (tob_queue.size() == 0);
    @(posedge clk);
  endtask

  task automatic add_row(logic kind, logic side, logic [plb_pkg::PriceW-1:0] price,
                         logic [plb_pkg::SizeW-1:0] qty, bit typed, tob_t res);
    row_t r;
    r.kind = kind;
    r.side = side;
    r.price = price;
    r.qty = qty;
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endtask

  always @(posedge clk) begin
    tob_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.best_bid = out_tdata[31:0];
      got.best_ask = out_tdata[63:32];
      got.mid      = out_tdata[96:64];
      got.nbid     = out_tdata[103:97];
      got.nask     = out_tdata[110:104];
      got.ok       = out_tdata[111];
      got.ovf      = out_tdata[112];
      if (tob_queue.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, got);
        errors++;
      end else begin
        want = tob_queue.pop_front();
        if (got.best_bid !== want.best_bid) begin
          $display("%0t best_bid expected %h actual %h", $time, want.best_bid, got.best_bid);
          errors++;
        end
        if (got.best_ask !== want.best_ask) begin
          $display("%0t best_ask expected %h actual %h", $time, want.best_ask, got.best_ask);
          errors++;
        end
        if (got.mid !== want.mid) begin
          $display("%0t mid expected %h actual %h", $time, want.mid, got.mid);
          errors++;
        end
        if (got.nbid !== want.nbid) begin
          $display("%0t bid_levels expected %0d actual %0d", $time, want.nbid, got.nbid);
          errors++;
        end
        if (got.nask !== want.nask) begin
          $display("%0t ask_levels expected %0d actual %0d", $time, want.nask, got.nask);
          errors++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t book_ok expected %b actual %b", $time, want.ok, got.ok);
          errors++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t overflow expected %b actual %b", $time, want.ovf, got.ovf);
          errors++;
        end
      end
    end
  end

  initial begin
    int mark;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < Levels; i++) begin
        lvl_live[k][i] = 0;
        lvl_price[k][i] = '0;
        lvl_qty[k][i] = '0;
      end
    end
    // best_bid, best_ask, mid, nbid, nask, ok, ovf
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd100, 48'd5, 1,
            '{32'd100, 32'd0, 33'd0, 7'd1, 7'd0, 1'b0, 1'b0});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1,
            '{32'd100, 32'hFFFF_FFFF, 33'h1_0000_0063, 7'd1, 7'd1, 1'b1, 1'b0});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'hFFFF_FFFF, 48'd1, 1,
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFE, 7'd2, 7'd1, 1'b1, 1'b0});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd7, 48'd0, 1,
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFE, 7'd2, 7'd1, 1'b1, 1'b0});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'd0, 48'd1, 1,
            '{32'hFFFF_FFFF, 32'd0, 33'h0_FFFF_FFFF, 7'd2, 7'd2, 1'b1, 1'b0});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'hFFFF_FFFF, 48'hAAAA_5555_AAAA, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'h5555_AAAA, 48'h5555_AAAA_5555, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'hFFFF_FFFF, 48'd0, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'd0, 48'd0, 0, '0);
    add_row(plb_pkg::KindClear, plb_pkg::SideAsk, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1,
            '{32'd0, 32'd0, 33'd0, 7'd0, 7'd0, 1'b0, 1'b0});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'd50, 48'd3, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'd40, 48'd3, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd30, 48'd9, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideAsk, 32'd40, 48'd0, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd30, 48'd0, 0, '0);
    add_row(plb_pkg::KindClear, plb_pkg::SideBid, 32'd0, 48'd0, 1,
            '{32'd0, 32'd0, 33'd0, 7'd0, 7'd0, 1'b0, 1'b0});
    // fill the bid side, then a dropped insert
    for (int i = 0; i < Levels; i++)
      add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd2000 + 32'(i), 48'd1, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd5000, 48'd1, 1,
            '{32'd2063, 32'd0, 33'd0, 7'd64, 7'd0, 1'b0, 1'b1});
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd2000, 48'd7, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd2063, 48'd0, 0, '0);
    add_row(plb_pkg::KindUpdate, plb_pkg::SideBid, 32'd5000, 48'd1, 0, '0);
    add_row(plb_pkg::KindClear, plb_pkg::SideBid, 32'd0, 48'd0, 1,
            '{32'd0, 32'd0, 33'd0, 7'd0, 7'd0, 1'b0, 1'b0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].side, dir_rows[i].price,
                dir_rows[i].qty, dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int n = 0; n < NumRand; n++) begin
      case (n / 70)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        3: begin tx_idle_pct = 17; rx_stall_pct = 17; end
        4: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      if (n == 300) begin
        rx_hold = 1'b1;
        fork
          begin
            repeat (3000) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      if (n == 200) drain();
      send_random((n % 140 < 100) ? 80 : 8);
    end
    in_tvalid <= 1'b0;

    mark = 0;
    while (tob_queue.size() != 0 && mark < 200000) begin
      @(posedge clk);
      mark++;
    end
    repeat (300) @(posedge clk);
    if (tob_queue.size() != 0) begin
      $display("%0t %0d expected transactions never arrived", $time, tob_queue.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
